/* design/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, codes and constants for the serial packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned HDR_LEN = 6;
  localparam logic [7:0] HDR_FIRST = 8'h49;  // 'I'
  localparam logic [7:0] TYPE_RPC = 8'h03;
  localparam logic [7:0] VERSION_RESET = 8'h01;
  localparam logic [7:0] RPC_LEN_OVERHEAD = 8'h02;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_RPC = 2'd3
  } status_t;

  // classified word handed from the front end to the back end
  typedef struct packed {
    logic kind;
    logic [7:0] pbyte;
    logic [7:0] idx;
    logic [7:0] ptype;
    logic [7:0] plen;
    logic ver_bad;
    logic sum_bad;
    logic rpc_bad;
  } spd_cmd_t;

  // "IMPROV" header bytes by position
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0: b = 8'h49;  // I
      3'd1: b = 8'h4D;  // M
      3'd2: b = 8'h50;  // P
      3'd3: b = 8'h52;  // R
      3'd4: b = 8'h4F;  // O
      3'd5: b = 8'h56;  // V
      default: b = 8'h49;
    endcase
    return b;
  endfunction

endpackage

/* design/spd_front.sv */
// ----------------------------------------------------------------------------
// spd_front
// Byte parser: header hunt, packet field capture, running checksum, and
// classification of each accepted word into a payload or end-of-packet word.
// ----------------------------------------------------------------------------
module spd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              push,
  output spd_pkg::spd_cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_VER  = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_PAY  = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  phase_t     phase;
  logic [2:0] header_matched;
  logic [7:0] accepted_version;
  logic [7:0] version_seen;
  logic [7:0] type_seen;
  logic [7:0] length_seen;
  logic [7:0] payload_count;
  logic [7:0] running_sum;
  logic [7:0] inner_length;

  logic [7:0] sum_next;
  logic [7:0] count_next;
  logic [2:0] matched_next;
  logic       hdr_hit;
  logic       rpc_bad;

  assign sum_next = running_sum + rx_byte;
  assign count_next = payload_count + 8'd1;
  assign matched_next = header_matched + 3'd1;
  assign hdr_hit = (rx_byte == spd_pkg::hdr_byte(header_matched));
  assign rpc_bad = (type_seen == spd_pkg::TYPE_RPC) &&
                   ((length_seen < spd_pkg::RPC_LEN_OVERHEAD) ||
                    (inner_length != (length_seen - spd_pkg::RPC_LEN_OVERHEAD)));

  always_comb begin
    push = 1'b0;
    cmd.kind = spd_pkg::KIND_PAYLOAD;
    cmd.pbyte = rx_byte;
    cmd.idx = payload_count;
    cmd.ptype = type_seen;
    cmd.plen = length_seen;
    cmd.ver_bad = 1'b0;
    cmd.sum_bad = 1'b0;
    cmd.rpc_bad = 1'b0;
    if (phase == PH_PAY) begin
      push = accept;
    end else if (phase == PH_SUM) begin
      push = accept;
      cmd.kind = spd_pkg::KIND_END;
      cmd.pbyte = 8'd0;
      cmd.idx = 8'd0;
      cmd.ver_bad = (version_seen != accepted_version);
      cmd.sum_bad = (rx_byte != running_sum);
      cmd.rpc_bad = rpc_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      header_matched <= 3'd0;
      accepted_version <= spd_pkg::VERSION_RESET;
      version_seen <= 8'd0;
      type_seen <= 8'd0;
      length_seen <= 8'd0;
      payload_count <= 8'd0;
      running_sum <= 8'd0;
      inner_length <= 8'd0;
    end else begin
      if (cfg_we) begin
        accepted_version <= cfg_wdata;
      end
      if (accept) begin
        unique case (phase)
          PH_VER: begin
            version_seen <= rx_byte;
            running_sum <= sum_next;
            phase <= PH_TYPE;
          end
          PH_TYPE: begin
            type_seen <= rx_byte;
            running_sum <= sum_next;
            phase <= PH_LEN;
          end
          PH_LEN: begin
            length_seen <= rx_byte;
            running_sum <= sum_next;
            payload_count <= 8'd0;
            inner_length <= 8'd0;
            phase <= (rx_byte == 8'd0) ? PH_SUM : PH_PAY;
          end
          PH_PAY: begin
            running_sum <= sum_next;
            if (payload_count == 8'd1) begin
              inner_length <= rx_byte;
            end
            payload_count <= count_next;
            if (count_next == length_seen) begin
              phase <= PH_SUM;
            end
          end
          PH_SUM: begin
            phase <= PH_HUNT;
            header_matched <= 3'd0;
            running_sum <= 8'd0;
          end
          default: begin
            // header hunt, restart on 'I' after a mismatch
            phase <= PH_HUNT;
            if (hdr_hit) begin
              running_sum <= (header_matched == 3'd0) ? rx_byte : sum_next;
              if (matched_next == 3'(spd_pkg::HDR_LEN)) begin
                header_matched <= 3'd0;
                phase <= PH_VER;
              end else begin
                header_matched <= matched_next;
              end
            end else if (rx_byte == spd_pkg::HDR_FIRST) begin
              running_sum <= rx_byte;
              header_matched <= 3'd1;
            end else begin
              running_sum <= 8'd0;
              header_matched <= 3'd0;
            end
          end
        endcase
      end
    end
  end

  a_pay_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (length_seen != 8'd0))
    else $error("payload phase with zero length");

  a_pay_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (payload_count < length_seen))
    else $error("payload count ran past declared length");

  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    header_matched < 3'(spd_pkg::HDR_LEN))
    else $error("header match count out of range");

endmodule

/* design/spd_fifo.sv */
// ----------------------------------------------------------------------------
// spd_fifo
// Short queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module spd_fifo #(
  parameter int unsigned DEPTH = spd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spd_pkg::spd_cmd_t wdata,
  input  logic              pop,
  output spd_pkg::spd_cmd_t rdata,
  output logic              nonempty,
  output logic              full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  spd_pkg::spd_cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("word pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

/* design/spd_back.sv */
// ----------------------------------------------------------------------------
// spd_back
// Output stage: resolves end-of-packet status and holds the result word
// until the consumer takes it.
// ----------------------------------------------------------------------------
module spd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  spd_pkg::spd_cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [7:0]        payload_byte,
  output logic [7:0]        byte_index,
  output logic [7:0]        packet_type,
  output logic [7:0]        payload_length,
  output logic [1:0]        status,
  output logic              last
);

  spd_pkg::status_t status_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // version beats checksum, checksum beats rpc length
  always_comb begin
    if (q_data.kind != spd_pkg::KIND_END) begin
      status_next = spd_pkg::ST_GOOD;
    end else if (q_data.ver_bad) begin
      status_next = spd_pkg::ST_BAD_VERSION;
    end else if (q_data.sum_bad) begin
      status_next = spd_pkg::ST_BAD_SUM;
    end else if (q_data.rpc_bad) begin
      status_next = spd_pkg::ST_BAD_RPC;
    end else begin
      status_next = spd_pkg::ST_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_kind <= q_data.kind;
      payload_byte <= q_data.pbyte;
      byte_index <= q_data.idx;
      packet_type <= q_data.ptype;
      payload_length <= q_data.plen;
      status <= status_next;
      last <= (q_data.kind == spd_pkg::KIND_END);
    end
  end

endmodule

/* design/serial_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// serial_packet_deframer_top
// Pulls IMPROV-framed packets out of a received byte stream.
// ----------------------------------------------------------------------------
// an accepted word goes into the result queue, then into the output register
// throughput: one byte per cycle while the result queue is not full;
// in_ready drops only when the QUEUE_DEPTH result queue is full
// reset: synchronous rst clears parser to header hunt, empties the queue,
//   drops out_valid and sets accepted version to 1
module serial_packet_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic [7:0] packet_type,
  output logic [7:0] payload_length,
  output logic [1:0] status,
  output logic       last
);

  spd_pkg::spd_cmd_t front_cmd;
  spd_pkg::spd_cmd_t q_data;
  logic              front_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  spd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (front_push),
    .cmd       (front_cmd)
  );

  spd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .wdata    (front_cmd),
    .pop      (q_pop),
    .rdata    (q_data),
    .nonempty (q_valid),
    .full     (q_full)
  );

  spd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .packet_type    (packet_type),
    .payload_length (payload_length),
    .status         (status),
    .last           (last)
  );

endmodule

/* bench/tb_serial_packet_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_packet_deframer_top
// Drives byte streams made of framed packets, header fragments and noise
// into the deframer. A parser written in the bench predicts every payload
// word and end-of-packet word, and the words that come out are compared
// field by field. The accepted version is changed between phases.
// ----------------------------------------------------------------------------
module tb_serial_packet_deframer_top;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD = 80;
  localparam logic [47:0] HDR_TEXT = "IMPROV";
  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_VER,
    PH_TYPE,
    PH_LEN,
    PH_PAY,
    PH_SUM
  } parse_phase_t;

  typedef struct packed {
    logic kind;
    logic [7:0] pbyte;
    logic [7:0] idx;
    logic [7:0] ptype;
    logic [7:0] plen;
    spd_pkg::status_t st;
    logic last;
  } deframe_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [7:0] packet_type;
  logic [7:0] payload_length;
  logic [1:0] status;
  logic last;

  // bench copy of the parser state
  parse_phase_t phase = PH_HUNT;
  logic [2:0] hdr_pos = 3'd0;
  logic [7:0] ver_seen = 8'h00;
  logic [7:0] type_seen = 8'h00;
  logic [7:0] len_seen = 8'h00;
  logic [7:0] pay_cnt = 8'h00;
  logic [7:0] csum = 8'h00;
  logic [7:0] inner_len = 8'h00;
  logic [7:0] accept_ver = spd_pkg::VERSION_RESET;

  logic [7:0] rx_feed[$];
  deframe_word_t due_words[$];

  int unsigned n_errors = 0;
  bit calm = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int quiet_cycles = 0;

  serial_packet_deframer_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .byte_index(byte_index),
    .packet_type(packet_type),
    .payload_length(payload_length),
    .status(status),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] hdr_at(input int pos);
    return HDR_TEXT[8 * (spd_pkg::HDR_LEN - 1 - pos) +: 8];
  endfunction

  // advance the parser by one accepted byte, queue the word it produces
  task automatic parse_rx_byte(input logic [7:0] b);
    deframe_word_t w;
    logic rpc_bad;
    w = '0;
    w.st = spd_pkg::ST_GOOD;
    case (phase)
      PH_VER: begin
        ver_seen = b;
        csum += b;
        phase = PH_TYPE;
      end
      PH_TYPE: begin
        type_seen = b;
        csum += b;
        phase = PH_LEN;
      end
      PH_LEN: begin
        len_seen = b;
        csum += b;
        pay_cnt = 8'h00;
        inner_len = 8'h00;
        phase = (b == 8'h00) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        csum += b;
        if (pay_cnt == 8'd1) inner_len = b;
        w.kind = spd_pkg::KIND_PAYLOAD;
        w.pbyte = b;
        w.idx = pay_cnt;
        w.ptype = type_seen;
        w.plen = len_seen;
        due_words.push_back(w);
        pay_cnt++;
        if (pay_cnt == len_seen) phase = PH_SUM;
      end
      PH_SUM: begin
        rpc_bad = (type_seen == spd_pkg::TYPE_RPC) &&
                  (len_seen < spd_pkg::RPC_LEN_OVERHEAD ||
                   inner_len != len_seen - spd_pkg::RPC_LEN_OVERHEAD);
        w.kind = spd_pkg::KIND_END;
        w.ptype = type_seen;
        w.plen = len_seen;
        w.last = 1'b1;
        if (ver_seen != accept_ver) w.st = spd_pkg::ST_BAD_VERSION;
        else if (b != csum) w.st = spd_pkg::ST_BAD_SUM;
        else if (rpc_bad) w.st = spd_pkg::ST_BAD_RPC;
        else w.st = spd_pkg::ST_GOOD;
        due_words.push_back(w);
        phase = PH_HUNT;
        hdr_pos = 3'd0;
        csum = 8'h00;
      end
      default: begin
        phase = PH_HUNT;
        if (b == hdr_at(hdr_pos)) begin
          csum = (hdr_pos == 3'd0) ? b : csum + b;
          hdr_pos++;
        end else if (b == spd_pkg::HDR_FIRST) begin
          // mismatch on an 'I' restarts the header match
          csum = b;
          hdr_pos = 3'd1;
        end else begin
          csum = 8'h00;
          hdr_pos = 3'd0;
        end
        if (hdr_pos == spd_pkg::HDR_LEN) begin
          hdr_pos = 3'd0;
          phase = PH_VER;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch on %s: got 0x%02h, want 0x%02h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic check_word();
    deframe_word_t want;
    if (due_words.size() == 0) begin
      report_mismatch("unexpected word", payload_byte, 8'h00);
      return;
    end
    want = due_words.pop_front();
    if (result_kind !== want.kind) report_mismatch("result_kind", result_kind, want.kind);
    if (payload_byte !== want.pbyte) report_mismatch("payload_byte", payload_byte, want.pbyte);
    if (byte_index !== want.idx) report_mismatch("byte_index", byte_index, want.idx);
    if (packet_type !== want.ptype) report_mismatch("packet_type", packet_type, want.ptype);
    if (payload_length !== want.plen)
      report_mismatch("payload_length", payload_length, want.plen);
    if (status !== want.st) report_mismatch("status", status, want.st);
    if (last !== want.last) report_mismatch("last", last, want.last);
  endtask

  // fill < 0 gives random payload; on rpc packets index 1 carries the inner length
  task automatic queue_packet(input logic [7:0] ver, input logic [7:0] ptype,
                              input logic [7:0] plen, input bit bad_sum,
                              input bit bad_inner, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    for (int i = 0; i < spd_pkg::HDR_LEN; i++) begin
      b = hdr_at(i);
      sum += b;
      rx_feed.push_back(b);
    end
    rx_feed.push_back(ver);
    rx_feed.push_back(ptype);
    rx_feed.push_back(plen);
    sum += ver + ptype + plen;
    for (int i = 0; i < plen; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      if (i == 1 && ptype == spd_pkg::TYPE_RPC)
        b = bad_inner ? 8'(plen - spd_pkg::RPC_LEN_OVERHEAD + $urandom_range(1, 255))
                      : plen - spd_pkg::RPC_LEN_OVERHEAD;
      sum += b;
      rx_feed.push_back(b);
    end
    rx_feed.push_back(bad_sum ? 8'(sum + $urandom_range(1, 255)) : sum);
  endtask

  // mostly well-formed packets, with noise and cut-off headers between them
  task automatic queue_random_traffic(input int n_bytes);
    int target;
    int pick;
    logic [7:0] ver;
    logic [7:0] ptype;
    logic [7:0] plen;
    target = rx_feed.size() + n_bytes;
    while (rx_feed.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) rx_feed.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        for (int i = 0; i < $urandom_range(1, 5); i++) rx_feed.push_back(hdr_at(i));
        rx_feed.push_back(8'($urandom_range(0, 255)));
      end
      ver = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : accept_ver;
      case ($urandom_range(0, 2))
        0: ptype = 8'($urandom_range(0, 255));
        1: ptype = spd_pkg::TYPE_RPC;
        default: ptype = 8'h01;
      endcase
      plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 40))
                                         : 8'($urandom_range(0, 6));
      queue_packet(ver, ptype, plen, $urandom_range(0, 7) == 0,
                   $urandom_range(0, 5) == 0, -1);
      if ($urandom_range(0, 1) == 0) rx_feed.push_back(NEWLINE);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (rx_feed.size() != 0 || in_valid || due_words.size() != 0);
    // bytes that make no word may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_version(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    accept_ver = v;
    @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (rx_feed.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (rx_feed.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= rx_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_word();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_granted != hold_requests) begin
        // long hold so the result queue fills and in_ready drops
        holds_granted <= holds_granted + 1;
        hold_left <= LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stray bytes, then a header broken by a second 'I'
    rx_feed.push_back(8'h00);
    rx_feed.push_back(8'hFF);
    rx_feed.push_back(hdr_at(0));
    rx_feed.push_back(hdr_at(1));
    rx_feed.push_back(hdr_at(2));
    queue_packet(spd_pkg::VERSION_RESET, 8'h00, 8'd2, 1'b0, 1'b0, 8'h00);
    rx_feed.push_back(NEWLINE);
    queue_packet(spd_pkg::VERSION_RESET, 8'h01, 8'd0, 1'b0, 1'b0, -1);
    queue_packet(spd_pkg::VERSION_RESET, spd_pkg::TYPE_RPC, 8'd4, 1'b0, 1'b0, -1);
    queue_packet(spd_pkg::VERSION_RESET, spd_pkg::TYPE_RPC, 8'd3, 1'b0, 1'b1, -1);
    queue_packet(spd_pkg::VERSION_RESET, spd_pkg::TYPE_RPC, 8'd1, 1'b0, 1'b0, -1);
    queue_packet(spd_pkg::VERSION_RESET, spd_pkg::TYPE_RPC, 8'd0, 1'b0, 1'b0, -1);
    // bad checksum wins over a malformed rpc, wrong version wins over both
    queue_packet(spd_pkg::VERSION_RESET, spd_pkg::TYPE_RPC, 8'd3, 1'b1, 1'b1, -1);
    queue_packet(8'hFF, spd_pkg::TYPE_RPC, 8'd2, 1'b1, 1'b1, -1);
    queue_packet(spd_pkg::VERSION_RESET, 8'hFF, 8'd3, 1'b0, 1'b0, 8'hFF);
    wait_drained();

    set_version(8'h00);
    queue_random_traffic(150);
    wait_drained();

    set_version(8'hFF);
    queue_random_traffic(150);
    wait_drained();

    set_version(8'($urandom_range(2, 254)));
    hold_requests++;
    queue_random_traffic(100);
    queue_packet(accept_ver, spd_pkg::TYPE_RPC, 8'd255, 1'b0, 1'b0, -1);
    queue_random_traffic(20);
    wait_drained();

    set_version(spd_pkg::VERSION_RESET);
    calm = 1'b1;
    queue_random_traffic(120);
    wait_drained();

    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
